>>> sv/cdq_pkg.sv
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int OUT_W    = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // cell commands
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_HOLD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SHR   = 3'd1; // shift towards the back
  localparam logic [CMD_W-1:0] CMD_PUSHB = 3'd2; // first empty cell loads
  localparam logic [CMD_W-1:0] CMD_SHL   = 3'd3; // shift towards the front
  localparam logic [CMD_W-1:0] CMD_ROT   = 3'd4; // rotate occupied cells

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
  } cdq_cell_ctl_t;

endpackage

>>> sv/cdq_cell.sv
`timescale 1ns / 1ps
module cdq_cell import cdq_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdq_cell_ctl_t        ctl,
  input  logic [WORD_BITS-1:0] new_word,
  input  logic [WORD_BITS-1:0] head_word,
  input  logic [WORD_BITS-1:0] prev_word,
  input  logic                 prev_valid,
  input  logic [WORD_BITS-1:0] next_word,
  input  logic                 next_valid,
  output logic [WORD_BITS-1:0] word,
  output logic                 valid
);

  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 valid_r, valid_nxt;

  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    case (ctl.cmd)
      CMD_HOLD: begin
      end
      CMD_SHR: begin
        word_nxt  = prev_word;
        valid_nxt = prev_valid;
      end
      CMD_PUSHB: begin
        if (!valid_r && prev_valid) begin
          word_nxt  = new_word;
          valid_nxt = 1'b1;
        end
      end
      CMD_SHL: begin
        word_nxt  = next_word;
        valid_nxt = next_valid;
      end
      CMD_ROT: begin
        // last occupied cell wraps round to the front word
        if (valid_r) begin
          word_nxt = next_valid ? next_word : head_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word  = word_r;
  assign valid = valid_r;

endmodule

>>> sv/circular_deque_with_search.sv
`timescale 1ns / 1ps
// Channel   Ports                                         Handshake
// input     in_operation, in_value                        start & !busy
// result    out_status, out_position, out_word, out_last  out_strobe, one cycle
//
// Pushes and pop front go straight through; the result appears the cycle after.
// Pop back, search and read-out step through the stored entries one by one:
// the entries rotate one cell per cycle past cell 0, which is the only
// place words are read. busy stays high until the ring is back in order.
// Reset (rst_n low, synchronous) empties the store; no clearing pass.
// The receiver cannot stall: every out_strobe pulse is one taken transaction.
module circular_deque_with_search import cdq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            in_operation,
  input  logic signed [31:0]         in_value,
  output logic                       out_strobe,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_position,
  output logic signed [OUT_W-1:0]    out_word,
  output logic                       out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // controller states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_POPB   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;

  logic                 strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [OUT_W-1:0]     oword_r, oword_nxt;
  logic                 last_r, last_nxt;

  cdq_cell_ctl_t        ctl;
  logic [WORD_BITS-1:0] in_fit;
  logic [OUT_W-1:0]     head_out;
  logic [CNT_W+4:0]     pos_ext;
  logic                 accept, is_full, is_empty, at_end;

  logic [WORD_BITS-1:0] cell_word [CAPACITY];
  logic                 cell_valid[CAPACITY];

  // input word cut or sign-extended to the stored width
  generate
    if (WORD_BITS <= 32) begin : g_fit_narrow
      assign in_fit = in_value[WORD_BITS-1:0];
    end else begin : g_fit_wide
      assign in_fit = {{(WORD_BITS-32){in_value[31]}}, in_value};
    end
    if (WORD_BITS >= OUT_W) begin : g_out_cut
      assign head_out = cell_word[0][OUT_W-1:0];
    end else begin : g_out_ext
      assign head_out = {{(OUT_W-WORD_BITS){cell_word[0][WORD_BITS-1]}}, cell_word[0]};
    end
  endgenerate

  // the chain: cell 0 is the front, occupied cells are contiguous
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [WORD_BITS-1:0] pw, nw;
      logic                 pv, nv;
      if (gi == 0) begin : g_first
        assign pw = in_fit;
        assign pv = 1'b1;
      end else begin : g_mid_p
        assign pw = cell_word[gi-1];
        assign pv = cell_valid[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign nw = '0;
        assign nv = 1'b0;
      end else begin : g_mid_n
        assign nw = cell_word[gi+1];
        assign nv = cell_valid[gi+1];
      end
      cdq_cell #(.WORD_BITS(WORD_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_word   (in_fit),
        .head_word  (cell_word[0]),
        .prev_word  (pw),
        .prev_valid (pv),
        .next_word  (nw),
        .next_valid (nv),
        .word       (cell_word[gi]),
        .valid      (cell_valid[gi])
      );
    end
  endgenerate

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign at_end   = (idx_r == count_r - 1'b1);
  assign pos_ext  = (CNT_W+5)'(idx_r) + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    key_nxt    = key_r;
    ctl.cmd    = CMD_HOLD;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    pos_nxt    = '0;
    oword_nxt  = '0;
    last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              strobe_nxt = 1'b1;
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.cmd   = (in_operation == OP_PUSH_FRONT) ? CMD_SHR : CMD_PUSHB;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_SEARCH, OP_READ_ALL: begin
              if (is_empty) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_EMPTY;
              end else if (in_operation == OP_POP_FRONT ||
                           (in_operation == OP_POP_BACK && count_r == CNT_W'(1))) begin
                strobe_nxt = 1'b1;
                oword_nxt  = head_out;
                ctl.cmd    = CMD_SHL;
                count_nxt  = count_r - 1'b1;
              end else begin
                idx_nxt   = '0;
                found_nxt = 1'b0;
                key_nxt   = in_fit;
                case (in_operation)
                  OP_POP_BACK: state_nxt = S_POPB;
                  OP_SEARCH:   state_nxt = S_SEARCH;
                  default:     state_nxt = S_READ;
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        ctl.cmd = CMD_ROT;
        idx_nxt = idx_r + 1'b1;
        if (!found_r && cell_word[0] == key_r) begin
          strobe_nxt = 1'b1;
          pos_nxt    = pos_ext[POS_W-1:0];
          oword_nxt  = head_out;
          found_nxt  = 1'b1;
        end else if (!found_r && at_end) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NOT_FOUND;
        end
        if (at_end) begin
          state_nxt = S_IDLE;
        end
      end

      S_READ: begin
        ctl.cmd    = CMD_ROT;
        idx_nxt    = idx_r + 1'b1;
        strobe_nxt = 1'b1;
        pos_nxt    = pos_ext[POS_W-1:0];
        oword_nxt  = head_out;
        last_nxt   = at_end;
        if (at_end) begin
          state_nxt = S_IDLE;
        end
      end

      S_POPB: begin
        // rotate the back entry round to cell 0, then take it off the front;
        // the rest lands back in order
        if (at_end) begin
          strobe_nxt = 1'b1;
          oword_nxt  = head_out;
          ctl.cmd    = CMD_SHL;
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          ctl.cmd = CMD_ROT;
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    oword_r  <= oword_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_position = pos_r;
  assign out_word     = oword_r;
  assign out_last     = last_r;

endmodule

>>> test/circular_deque_with_search_tb.sv
`timescale 1ns / 1ps
// Deque bench: directed table first, then three random phases with
// different idle patterns on the command side. Every accepted command
// transaction is run through a local copy of the ring to build the queue
// of awaited result transactions; every out_strobe pulse pops one.
module circular_deque_with_search_tb;
  import cdq_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int PHASE_ITEMS   = 134;    // valid commands per random phase
  localparam int SEGMENT_ITEMS = 30;     // fill / drain bias held this long
  localparam int SETTLE_CYCLES = 4 * CAP;
  localparam int CYCLE_LIMIT   = 200_000;

  // codes the block must ignore
  localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [31:0]         word;
    logic                last;
  } deque_result_t;

  // one row of the directed table; hand_result only used when by_hand is set
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0]     value;
    int              reps;
    logic            by_hand;
    deque_result_t   hand_result;
  } plan_row_t;

  localparam int PLAN_ROWS = 16;

  // Store ends up 16 deep: MIN, MAX, 13 x 0x55555555, -1, wrapped past slot 0
  // because the first push goes in at the front.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{OP_POP_FRONT,  32'd0,        1,  1'b1, '{ST_EMPTY,     5'd0,  32'd0,     1'b1}},
    '{OP_POP_BACK,   WORD_ONES,    1,  1'b1, '{ST_EMPTY,     5'd0,  32'd0,     1'b1}},
    '{OP_SEARCH,     32'd0,        1,  1'b1, '{ST_EMPTY,     5'd0,  32'd0,     1'b1}},
    '{OP_READ_ALL,   32'd0,        1,  1'b1, '{ST_EMPTY,     5'd0,  32'd0,     1'b1}},
    '{OP_RESERVED_A, 32'h1234_5678, 1, 1'b0, '0},
    '{OP_PUSH_FRONT, WORD_MIN,     1,  1'b1, '{ST_OK,        5'd0,  32'd0,     1'b1}},
    '{OP_PUSH_BACK,  WORD_MAX,     1,  1'b1, '{ST_OK,        5'd0,  32'd0,     1'b1}},
    '{OP_PUSH_BACK,  32'h5555_5555, 13, 1'b1, '{ST_OK,       5'd0,  32'd0,     1'b1}},
    '{OP_PUSH_BACK,  WORD_ONES,    1,  1'b1, '{ST_OK,        5'd0,  32'd0,     1'b1}},
    '{OP_PUSH_FRONT, 32'd0,        1,  1'b1, '{ST_FULL,      5'd0,  32'd0,     1'b1}},
    '{OP_PUSH_BACK,  32'd1,        1,  1'b1, '{ST_FULL,      5'd0,  32'd0,     1'b1}},
    // match on the very last entry
    '{OP_SEARCH,     WORD_ONES,    1,  1'b1, '{ST_OK,        5'd16, WORD_ONES, 1'b1}},
    '{OP_SEARCH,     32'd0,        1,  1'b1, '{ST_NOT_FOUND, 5'd0,  32'd0,     1'b1}},
    '{OP_READ_ALL,   32'd0,        1,  1'b0, '0},
    '{OP_POP_FRONT,  32'hAAAA_AAAA, 1, 1'b1, '{ST_OK,        5'd0,  WORD_MIN,  1'b1}},
    '{OP_POP_BACK,   32'd0,        1,  1'b1, '{ST_OK,        5'd0,  WORD_ONES, 1'b1}}
  };

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_operation = '0;
  logic signed [31:0]      in_value = '0;
  logic                    out_strobe;
  logic [STATUS_W-1:0]     out_status;
  logic [POS_W-1:0]        out_position;
  logic signed [OUT_W-1:0] out_word;
  logic                    out_last;

  // travels with the command: typed-in expectation for directed rows
  logic          cmd_by_hand = 1'b0;
  deque_result_t cmd_hand_result = '0;

  circular_deque_with_search dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_position (out_position),
    .out_word     (out_word),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Local copy of the ring
  // ---------------------------------------------------------------------
  logic [31:0]   ring_words [CAP];
  int            ring_head  = 0;
  int            ring_count = 0;
  deque_result_t fresh_results  [$];   // results of the latest command
  deque_result_t awaited_results [$];  // oldest first
  logic [31:0]   recent_words   [$];   // words pushed lately, for hits
  int            error_count = 0;
  int            cycle_count = 0;

  function automatic deque_result_t mk_result(logic [STATUS_W-1:0] status,
                                              int position, logic [31:0] word,
                                              logic last);
    deque_result_t r;
    r.status   = status;
    r.position = position[POS_W-1:0];
    r.word     = word;
    r.last     = last;
    return r;
  endfunction

  function void step_ring(input logic [OP_W-1:0] op, input logic [31:0] value);
    int i;
    bit hit;
    fresh_results.delete();
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      if (ring_count >= CAP) begin
        fresh_results.push_back(mk_result(ST_FULL, 0, '0, 1'b1));
      end else begin
        if (op == OP_PUSH_FRONT) begin
          ring_head = (ring_head + CAP - 1) % CAP;
          ring_words[ring_head] = value;
        end else begin
          ring_words[(ring_head + ring_count) % CAP] = value;
        end
        ring_count++;
        fresh_results.push_back(mk_result(ST_OK, 0, '0, 1'b1));
      end
    end else if (op == OP_POP_FRONT || op == OP_POP_BACK || op == OP_SEARCH ||
                 op == OP_READ_ALL) begin
      if (ring_count == 0) begin
        fresh_results.push_back(mk_result(ST_EMPTY, 0, '0, 1'b1));
      end else begin
        case (op)
          OP_POP_FRONT: begin
            fresh_results.push_back(mk_result(ST_OK, 0, ring_words[ring_head], 1'b1));
            ring_head = (ring_head + 1) % CAP;
            ring_count--;
          end
          OP_POP_BACK: begin
            ring_count--;
            fresh_results.push_back(
              mk_result(ST_OK, 0, ring_words[(ring_head + ring_count) % CAP], 1'b1));
          end
          OP_SEARCH: begin
            // first match wins; the tail entry is searched too
            hit = 1'b0;
            for (i = 0; i < ring_count && !hit; i++) begin
              if (ring_words[(ring_head + i) % CAP] == value) begin
                hit = 1'b1;
                fresh_results.push_back(mk_result(ST_OK, i + 1, value, 1'b1));
              end
            end
            if (!hit) fresh_results.push_back(mk_result(ST_NOT_FOUND, 0, '0, 1'b1));
          end
          default: begin
            for (i = 0; i < ring_count; i++) begin
              fresh_results.push_back(mk_result(ST_OK, i + 1,
                                                ring_words[(ring_head + i) % CAP],
                                                i + 1 == ring_count));
            end
          end
        endcase
      end
    end
    // reserved codes: nothing comes out, nothing changes
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: check result transactions, predict on accepted commands.
  // Everything is sampled at the rising edge, before the NBA updates.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    deque_result_t seen;
    deque_result_t want;
    if (rst_n && out_strobe) begin
      seen = '{out_status, out_position, out_word, out_last};
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got st=%0d pos=%0d word=%h last=%b",
                 $time, seen.status, seen.position, seen.word, seen.last);
      end else begin
        want = awaited_results.pop_front();
        if (seen !== want) begin
          error_count++;
          $display("%0t: result mismatch, expected st=%0d pos=%0d word=%h last=%b, got st=%0d pos=%0d word=%h last=%b",
                   $time, want.status, want.position, want.word, want.last,
                   seen.status, seen.position, seen.word, seen.last);
        end
      end
    end
    if (rst_n && start && !busy) begin
      step_ring(in_operation, in_value);
      if (cmd_by_hand) awaited_results.push_back(cmd_hand_result);
      else foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------
  // Present one command and hold it until the edge that takes it.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [31:0] value,
                          input logic by_hand, input deque_result_t hand_result);
    start           <= 1'b1;
    in_operation    <= op;
    in_value        <= value;
    cmd_by_hand     <= by_hand;
    cmd_hand_result <= hand_result;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every awaited result has come out. Polled on the falling
  // edge so the monitor's pushes and pops are settled.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Word source: recently pushed words (to force hits and duplicates),
  // the extremes, or anything at all.
  function automatic logic [31:0] pick_word(int pool_pct);
    int r;
    logic [31:0] w;
    r = $urandom_range(99);
    w = $urandom;
    if (r < pool_pct && recent_words.size() != 0) begin
      w = recent_words[$urandom_range(recent_words.size() - 1)];
    end else if (r < pool_pct + 15) begin
      case ($urandom_range(3))
        0: w = WORD_MIN;
        1: w = WORD_MAX;
        2: w = '0;
        default: w = WORD_ONES;
      endcase
    end
    return w;
  endfunction

  // Random commands. Bias alternates at random between filling and
  // draining so the store hits both full and empty regularly. Reserved
  // codes are sprinkled in but do not count towards n_items.
  task automatic run_random(input int n_items, input int gap_pct);
    int done;
    int r;
    bit fill_bias;
    logic [OP_W-1:0] op;
    logic [31:0] value;
    done = 0;
    fill_bias = 1'b1;
    while (done < n_items) begin
      if (done % SEGMENT_ITEMS == 0) fill_bias = $urandom_range(1);
      while ($urandom_range(99) < gap_pct) idle_cycle();
      if ($urandom_range(99) < 2) drain_results();
      r = $urandom_range(99);
      if (fill_bias) begin
        if (r < 60)      op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < 75) op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        else if (r < 89) op = OP_SEARCH;
        else if (r < 96) op = OP_READ_ALL;
        else             op = $urandom_range(1) ? OP_RESERVED_A : OP_RESERVED_B;
      end else begin
        if (r < 25)      op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < 70) op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        else if (r < 85) op = OP_SEARCH;
        else if (r < 95) op = OP_READ_ALL;
        else             op = $urandom_range(1) ? OP_RESERVED_A : OP_RESERVED_B;
      end
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          value = pick_word(30);
          recent_words.push_back(value);
          if (recent_words.size() > 2 * CAP) void'(recent_words.pop_front());
        end
        OP_SEARCH: value = pick_word(60);
        default:   value = $urandom;  // ignored by the block
      endcase
      send_cmd(op, value, 1'b0, '0);
      if (op != OP_RESERVED_A && op != OP_RESERVED_B) done++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, back to back
    foreach (directed_plan[n]) begin
      for (int k = 0; k < directed_plan[n].reps; k++) begin
        send_cmd(directed_plan[n].op, directed_plan[n].value,
                 directed_plan[n].by_hand, directed_plan[n].hand_result);
      end
    end
    drain_results();

    // sender idles now and then, then often, then never
    run_random(PHASE_ITEMS, 21);
    drain_results();
    run_random(PHASE_ITEMS, 79);
    drain_results();
    run_random(PHASE_ITEMS, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
